### design/slr_pkg.sv
// Shared constants for the stereo linear resampler.
`default_nettype none
package slr_pkg;
    localparam int STEP_W = 21;
    localparam logic [STEP_W-1:0] STEP_RESET = 21'd60211;
    localparam int MAX_OUT = 16;
    localparam int CNT_W = $clog2(MAX_OUT);
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_STEP_RATIO = 1'b0;
endpackage
`default_nettype wire

### design/stereo_linear_resampler_core.sv
// Stereo linear-interpolation resampler with a fixed-point phase accumulator.
//
// Input stream s_*: one stereo word per frame, tdata = {right, left}, left in the
// low bits. Output stream m_*: one interpolated stereo word per emitted frame,
// same tdata layout, tlast marks the last word caused by an input frame.
// An input frame with the phase already at one or more emits nothing.
// APB port: register 0 at byte address 0 is step_ratio (unsigned, 16 fraction bits).
//
// Each output word is built on one shared multiplier, left then right: the
// sequencer steps through ST_MUL_L, ST_MUL_R and ST_FIN, and the word then
// sits in the output register in ST_SEND. A frame that emits nothing leaves
// the sequencer idle. At most 16 words per frame.
// s_tready is high only while idle. A stalled receiver holds the word in the
// output register and the sequencer waits.
// Reset clears the sample window and the phase to zero and loads the default step.
`default_nettype none
module stereo_linear_resampler_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // in_left, in_right
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // out_left, out_right
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         m_tdata,
    output logic                                       m_tlast,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [slr_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire logic [slr_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [slr_pkg::APB_DATA_W-1:0]             prdata,
    output logic                                       pready
);
    localparam int TDATA_W = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int STEP_W = slr_pkg::STEP_W;
    localparam int PHASE_W = ((STEP_W > FRAC_BITS) ? STEP_W : FRAC_BITS) + 1;
    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
    localparam int CNT_W = slr_pkg::CNT_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(slr_pkg::MAX_OUT - 1);
    localparam int APB_ADDR_W_HI = slr_pkg::APB_ADDR_W - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_FIN,
        ST_SEND
    } state_t;

    state_t                         state_reg;
    logic [STEP_W-1:0]              step_reg;
    logic [PHASE_W-1:0]             phase_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic signed [SAMPLE_BITS-1:0]  older_l_reg, older_r_reg, newer_l_reg, newer_r_reg;
    logic signed [SAMPLE_BITS:0]    diff_l_reg, diff_r_reg;
    logic signed [SAMPLE_BITS-1:0]  out_l_reg, out_r_reg;
    logic                           valid_reg, last_reg;

    logic signed [SAMPLE_BITS-1:0]  in_l, in_r;
    logic                           in_fire, out_fire, cfg_wr;
    logic [PHASE_W-1:0]             phase_next;
    logic                           lerp_load;
    logic signed [SAMPLE_BITS:0]    lerp_diff, lerp_delta;
    logic signed [SAMPLE_BITS:0]    base_sel, sum_next;

    assign in_l = s_tdata[SAMPLE_BITS-1:0];
    assign in_r = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_fire = s_tvalid && s_tready;
    assign out_fire = valid_reg && m_tready;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W_HI:2] == slr_pkg::REG_STEP_RATIO);

    assign phase_next = phase_reg + PHASE_W'(step_reg);
    assign lerp_load = (state_reg == ST_MUL_L) || (state_reg == ST_MUL_R);
    assign lerp_diff = (state_reg == ST_MUL_L) ? diff_l_reg : diff_r_reg;
    assign base_sel = (state_reg == ST_MUL_R) ? (SAMPLE_BITS+1)'(older_l_reg)
                                              : (SAMPLE_BITS+1)'(older_r_reg);
    assign sum_next = base_sel + lerp_delta;

    slr_lerp #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_lerp (
        .aclk(aclk),
        .load(lerp_load),
        .diff(lerp_diff),
        .frac(phase_reg[FRAC_BITS-1:0]),
        .delta(lerp_delta)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= slr_pkg::STEP_RESET;
            phase_reg   <= '0;
            cnt_reg     <= '0;
            older_l_reg <= '0;
            older_r_reg <= '0;
            newer_l_reg <= '0;
            newer_r_reg <= '0;
            valid_reg   <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                step_reg <= pwdata[STEP_W-1:0];
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        older_l_reg <= newer_l_reg;
                        older_r_reg <= newer_r_reg;
                        newer_l_reg <= in_l;
                        newer_r_reg <= in_r;
                        diff_l_reg  <= (SAMPLE_BITS+1)'(in_l) - (SAMPLE_BITS+1)'(newer_l_reg);
                        diff_r_reg  <= (SAMPLE_BITS+1)'(in_r) - (SAMPLE_BITS+1)'(newer_r_reg);
                        cnt_reg     <= '0;
                        if (phase_reg >= PHASE_ONE) begin
                            phase_reg <= phase_reg - PHASE_ONE;
                        end else begin
                            state_reg <= ST_MUL_L;
                        end
                    end
                end
                ST_MUL_L: begin
                    state_reg <= ST_MUL_R;
                end
                ST_MUL_R: begin
                    out_l_reg <= sum_next[SAMPLE_BITS-1:0];
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    out_r_reg <= sum_next[SAMPLE_BITS-1:0];
                    phase_reg <= phase_next;
                    last_reg  <= (phase_next >= PHASE_ONE) || (cnt_reg == CNT_LAST);
                    valid_reg <= 1'b1;
                    state_reg <= ST_SEND;
                end
                ST_SEND: begin
                    if (out_fire) begin
                        valid_reg <= 1'b0;
                        cnt_reg   <= cnt_reg + CNT_W'(1);
                        if (last_reg) begin
                            phase_reg <= (phase_reg >= PHASE_ONE) ? phase_reg - PHASE_ONE
                                                                  : '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_MUL_L;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = TDATA_W'({out_r_reg, out_l_reg});
    assign pready   = 1'b1;
    assign prdata   = slr_pkg::APB_DATA_W'(step_reg);

    a_valid_in_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == ST_SEND))
        else $error("output valid outside send state");

    a_not_last_loops: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && !m_tlast) |=> (state_reg == ST_MUL_L))
        else $error("non-final word did not start the next output");

    a_phase_below_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_L) |-> (phase_reg < PHASE_ONE))
        else $error("interpolating with phase at or above one");

    a_ready_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input ready while a word waits");
endmodule
`default_nettype wire

### design/slr_lerp.sv
// Shared multiply unit: registered diff*frac, then floor shift by the fraction width.
`default_nettype none
module slr_lerp #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          load,
    input  wire logic signed [SAMPLE_BITS:0]   diff,
    input  wire logic        [FRAC_BITS-1:0]   frac,
    output logic signed      [SAMPLE_BITS:0]   delta
);
    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_shift;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= PROD_W'(diff * $signed({1'b0, frac}));
        end
    end

    // arithmetic shift gives floor for negative products
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign delta = prod_shift[SAMPLE_BITS:0];
endmodule
`default_nettype wire
